// ===== src/srpt_pkg.sv =====
// Shared types and constants for the stepper reel position tracker.
`timescale 1ns / 1ps
`default_nettype none
package srpt_pkg;

  localparam int unsigned NUM_MOTORS_DEF = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned MOTOR_W  = 3;
  localparam int unsigned PAT_W    = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONFIG = 2'd2;

  localparam logic [KIND_W-1:0] KIND_A        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_B        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TWO_LINE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DICE     = 2'd3;

  localparam logic [POS_W:0] SPAN_REEL = 10'd96;
  localparam logic [POS_W:0] SPAN_DICE = 10'd288;

  localparam logic [PHASE_W-1:0] PHASE_HOME = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [MOTOR_W-1:0] motor;
    logic [PAT_W-1:0]   coil_pattern;
    logic [KIND_W-1:0]  reel_kind;
    logic               spins_backward;
    logic [POS_W-1:0]   window_start;
    logic [POS_W-1:0]   window_end;
    logic [PAT_W-1:0]   window_pattern;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               backward;
    logic [POS_W-1:0]   win_start;
    logic [POS_W-1:0]   win_end;
    logic [PAT_W-1:0]   need_pat;
    logic [PHASE_W-1:0] phase_now;
    logic [PHASE_W-1:0] phase_before;
    logic [PAT_W-1:0]   pat_now;
    logic [PAT_W-1:0]   pat_before;
    logic [POS_W-1:0]   pos;
    logic               optic;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [MOTOR_W-1:0] idx;
    entry_t             data;
  } table_wr_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             optic;
    logic             moved;
  } result_t;

endpackage
`default_nettype wire

// ===== src/stepper_reel_position_tracker_core.sv =====
// Top level of the stepper reel position tracker: request and result registers.
//
//  channel | ports                     | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_tvalid/tready/tdata/user | tuser: cmd; tdata: motor, coil,
//          |                           |   kind, backward, window start/end/pat
//  out     | out_tvalid/tready/tdata   | tdata: position, optic, moved
//
//  One request per cycle unless the output stalls; request and result each
//  sit in a register. The motor state is read and written in the same cycle,
//  so back-to-back requests to one motor see each other's effect.
//  Synchronous reset clears all motor entries and both valid flags.
//  A stalled result holds in the output register; one more request waits in the
//  request register, then in_tready drops until the result drains.
`timescale 1ns / 1ps
`default_nettype none
module stepper_reel_position_tracker_core #(
  parameter int unsigned NUM_MOTORS = srpt_pkg::NUM_MOTORS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [2:0] motor, [10:3] coil_pattern, [12:11] reel_kind, [13] spins_backward,
  // [22:14] window_start, [31:23] window_end, [39:32] window_pattern
  input  wire logic [srpt_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] cmd
  input  wire logic [srpt_pkg::CMD_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [8:0] position, [9] optic, [10] moved, [15:11] zero
  output logic [srpt_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int unsigned MAX_MOTORS = 2 ** srpt_pkg::MOTOR_W;
  localparam int unsigned DEPTH = (NUM_MOTORS < MAX_MOTORS) ? NUM_MOTORS : MAX_MOTORS;

  logic                in_valid_r, in_valid_nxt;
  srpt_pkg::item_t     item_r, item_nxt, item_in;
  logic                out_valid_r, out_valid_nxt;
  srpt_pkg::result_t   res_r, res_nxt;
  logic                fire;
  logic                in_accept;
  logic                in_range;
  srpt_pkg::entry_t    cur_entry;
  srpt_pkg::table_wr_t table_wr;
  srpt_pkg::result_t   step_res;

  always_comb begin
    item_in.cmd            = in_tuser;
    item_in.motor          = in_tdata[2:0];
    item_in.coil_pattern   = in_tdata[10:3];
    item_in.reel_kind      = in_tdata[12:11];
    item_in.spins_backward = in_tdata[13];
    item_in.window_start   = in_tdata[22:14];
    item_in.window_end     = in_tdata[31:23];
    item_in.window_pattern = in_tdata[39:32];
  end

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign in_accept = in_tvalid && in_tready;
  assign in_range  = int'(item_r.motor) < NUM_MOTORS;

  srpt_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (item_r.motor),
    .rd_entry (cur_entry),
    .wr       ('{en: table_wr.en && fire, idx: table_wr.idx, data: table_wr.data})
  );

  srpt_step u_step (
    .item     (item_r),
    .in_range (in_range),
    .cur      (cur_entry),
    .wr       (table_wr),
    .res      (step_res)
  );

  always_comb begin
    in_valid_nxt = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_r);
    item_nxt = in_accept ? item_in : item_r;
    out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    res_nxt = fire ? step_res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.moved, res_r.optic, res_r.position};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r)
    else $error("request stage blocked while empty");

  a_fire_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

  a_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !fire) |=> (in_valid_r && $stable(item_r)))
    else $error("pending request lost or changed");

  a_moved_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (item_r.cmd != srpt_pkg::CMD_UPDATE)) |-> !step_res.moved)
    else $error("moved flag raised by a non-update request");

  a_position_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> ({1'b0, step_res.position} < srpt_pkg::SPAN_DICE))
    else $error("position beyond reel span");

endmodule
`default_nettype wire

// ===== src/srpt_table.sv =====
// Per-motor state entries held in flip-flops, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none
module srpt_table #(
  parameter int unsigned DEPTH = srpt_pkg::NUM_MOTORS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [srpt_pkg::MOTOR_W-1:0]  rd_idx,
  output srpt_pkg::entry_t                   rd_entry,
  input  wire srpt_pkg::table_wr_t           wr
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  srpt_pkg::entry_t entries_r [DEPTH];

  always_comb begin
    if (int'(rd_idx) < DEPTH) begin
      rd_entry = entries_r[rd_idx[IDX_W-1:0]];
    end else begin
      rd_entry = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries_r[i] <= '0;
      end
    end else if (wr.en && (int'(wr.idx) < DEPTH)) begin
      entries_r[wr.idx[IDX_W-1:0]] <= wr.data;
    end
  end

endmodule
`default_nettype wire

// ===== src/srpt_step.sv =====
// Phase decode, position step, wrap and index optic for one request, plus the reset and config entry updates.
`timescale 1ns / 1ps
`default_nettype none
module srpt_step (
  input  wire srpt_pkg::item_t   item,
  input  wire logic              in_range,
  input  wire srpt_pkg::entry_t  cur,
  output srpt_pkg::table_wr_t    wr,
  output srpt_pkg::result_t      res
);

  typedef struct packed {
    logic                         hit;
    logic [srpt_pkg::PHASE_W-1:0] phase;
  } phase_dec_t;

  function automatic phase_dec_t decode_phase(
    input logic [srpt_pkg::KIND_W-1:0]  kind,
    input logic [srpt_pkg::PAT_W-1:0]   pat,
    input logic [srpt_pkg::PHASE_W-1:0] prev
  );
    logic [srpt_pkg::PHASE_W-1:0] north;
    logic [srpt_pkg::PHASE_W-1:0] east;
    phase_dec_t d;
    north = (prev == 3'd6 || prev == 3'd0) ? 3'd7 : 3'd3;
    east  = (prev == 3'd6 || prev == 3'd4) ? 3'd5 : 3'd1;
    d.hit = 1'b1;
    d.phase = '0;
    if (kind == srpt_pkg::KIND_B) begin
      case (pat)
        8'h01:   d.phase = 3'd7;
        8'h03:   d.phase = 3'd6;
        8'h02:   d.phase = 3'd5;
        8'h06:   d.phase = 3'd4;
        8'h04:   d.phase = 3'd3;
        8'h0C:   d.phase = 3'd2;
        8'h08:   d.phase = 3'd1;
        8'h09:   d.phase = 3'd0;
        8'h05:   d.phase = north;
        8'h0A:   d.phase = east;
        default: d.hit = 1'b0;
      endcase
    end else if (kind == srpt_pkg::KIND_TWO_LINE) begin
      case (pat)
        8'h00:   d.phase = 3'd6;
        8'h01:   d.phase = 3'd4;
        8'h03:   d.phase = 3'd2;
        8'h02:   d.phase = 3'd0;
        default: d.hit = 1'b0;
      endcase
    end else begin
      case (pat)
        8'h02:   d.phase = 3'd7;
        8'h06:   d.phase = 3'd6;
        8'h04:   d.phase = 3'd5;
        8'h05:   d.phase = 3'd4;
        8'h01:   d.phase = 3'd3;
        8'h09:   d.phase = 3'd2;
        8'h08:   d.phase = 3'd1;
        8'h0A:   d.phase = 3'd0;
        8'h03:   d.phase = north;
        8'h0C:   d.phase = east;
        default: d.hit = 1'b0;
      endcase
    end
    return d;
  endfunction

  function automatic logic optic_eval(input srpt_pkg::entry_t e);
    logic in_win;
    logic match;
    if (e.win_start > e.win_end) begin
      in_win = (e.pos > e.win_start) || (e.pos < e.win_end);
    end else begin
      in_win = (e.pos > e.win_start) && (e.pos < e.win_end);
    end
    match = (e.pat_now == e.need_pat) || (e.need_pat == '0) ||
            ((e.pat_now == '0) && (e.pat_before == e.need_pat));
    return in_win && match;
  endfunction

  phase_dec_t                   dec;
  logic [srpt_pkg::PHASE_W-1:0] phase_new;
  logic signed [3:0]            diff_raw;
  logic signed [3:0]            diff_wrap;
  logic signed [3:0]            diff_dir;
  logic [srpt_pkg::POS_W:0]     span;
  logic [srpt_pkg::POS_W+1:0]   pos_sum;
  logic [srpt_pkg::POS_W+1:0]   pos_wrap;
  logic [srpt_pkg::POS_W-1:0]   pos_step;
  logic                         home_kind;
  srpt_pkg::entry_t             nxt;
  logic                         moved;

  always_comb begin
    dec = decode_phase(cur.kind, item.coil_pattern, cur.phase_before);
    phase_new = dec.hit ? dec.phase : cur.phase_now;
    diff_raw = $signed({1'b0, cur.phase_before}) - $signed({1'b0, phase_new});
    if (diff_raw < -4'sd4) begin
      diff_wrap = diff_raw + 4'sd8;
    end else if (diff_raw > 4'sd4) begin
      diff_wrap = diff_raw - 4'sd8;
    end else begin
      diff_wrap = diff_raw;
    end
    diff_dir = cur.backward ? -diff_wrap : diff_wrap;
    span = (cur.kind == srpt_pkg::KIND_DICE) ? srpt_pkg::SPAN_DICE : srpt_pkg::SPAN_REEL;
    pos_sum = {2'b00, cur.pos} + {{(srpt_pkg::POS_W - 2){diff_dir[3]}}, diff_dir};
    if (pos_sum[srpt_pkg::POS_W+1]) begin
      pos_wrap = pos_sum + {1'b0, span};
    end else if (pos_sum >= {1'b0, span}) begin
      pos_wrap = pos_sum - {1'b0, span};
    end else begin
      pos_wrap = pos_sum;
    end
    pos_step = pos_wrap[srpt_pkg::POS_W-1:0];
    home_kind = (cur.kind == srpt_pkg::KIND_A) || (cur.kind == srpt_pkg::KIND_DICE);
  end

  always_comb begin
    nxt = cur;
    moved = 1'b0;
    wr.en = 1'b0;
    case (item.cmd)
      srpt_pkg::CMD_UPDATE: begin
        nxt.pat_now = item.coil_pattern;
        nxt.pat_before = item.coil_pattern;
        nxt.phase_now = phase_new;
        nxt.phase_before = phase_new;
        nxt.pos = pos_step;
        nxt.optic = optic_eval(nxt);
        moved = (pos_step != cur.pos);
        wr.en = 1'b1;
      end
      srpt_pkg::CMD_RESET: begin
        nxt.pos = '0;
        nxt.pat_now = '0;
        nxt.pat_before = '0;
        nxt.phase_now = '0;
        if (home_kind) begin
          nxt.phase_now = srpt_pkg::PHASE_HOME;
          nxt.phase_before = srpt_pkg::PHASE_HOME;
        end
        nxt.optic = optic_eval(nxt);
        wr.en = 1'b1;
      end
      srpt_pkg::CMD_CONFIG: begin
        nxt.kind = item.reel_kind;
        nxt.backward = item.spins_backward;
        nxt.win_start = item.window_start;
        nxt.win_end = item.window_end;
        nxt.need_pat = item.window_pattern;
        nxt.phase_now = '0;
        nxt.pat_now = '0;
        nxt.pat_before = '0;
        nxt.pos = '0;
        wr.en = 1'b1;
      end
      default: begin
      end
    endcase
    wr.idx = item.motor;
    wr.data = nxt;
    if (in_range) begin
      res.position = nxt.pos;
      res.optic = nxt.optic;
      res.moved = moved;
    end else begin
      wr.en = 1'b0;
      res = '0;
    end
  end

endmodule
`default_nettype wire
